@@ rtl/core/inla_pkg.sv @@
// ----------------------------------------------------------------------------
// inla_pkg - shared types and constants for the nesting level assigner
// Field widths of the request and response channels and the select code of
// the shared compare unit.
// ----------------------------------------------------------------------------
`default_nettype none

package inla_pkg;

   localparam int TIME_W  = 62;
   localparam int END_W   = 63;
   localparam int TYPE_W  = 3;
   localparam int LEVEL_W = 6;
   localparam int ROWS_W  = 7;

   typedef enum logic {
      CMP_STACK,
      CMP_BASE
   } cmp_sel_type;

endpackage

`default_nettype wire

@@ rtl/core/inla_stack_mem.sv @@
// ----------------------------------------------------------------------------
// inla_stack_mem - end time store for all nesting stacks
// One write port and one read port with registered read data. A valid bit
// per entry makes never written entries read as zero right after reset.
// ----------------------------------------------------------------------------
`default_nettype none

module inla_stack_mem #(
   parameter int ENTRIES = 192,
   parameter int AW      = 8
) (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire logic                      rd_en,
   input  wire logic [AW-1:0]             rd_addr,
   output      logic [inla_pkg::END_W-1:0] rd_data,
   input  wire logic                      wr_en,
   input  wire logic [AW-1:0]             wr_addr,
   input  wire logic [inla_pkg::END_W-1:0] wr_data
);
   import inla_pkg::*;

   logic [END_W-1:0] mem_ff [ENTRIES];
   logic [ENTRIES-1:0] valid_ff;
   logic [END_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= valid_ff[rd_addr] ? mem_ff[rd_addr] : '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (wr_en) begin
         valid_ff[wr_addr] <= 1'b1;
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

@@ rtl/core/inla_cmp_unit.sv @@
// ----------------------------------------------------------------------------
// inla_cmp_unit - shared 63-bit magnitude compare
// Checks a stack end time against the request start, or the request start
// against the base event end time.
// ----------------------------------------------------------------------------
`default_nettype none

module inla_cmp_unit (
   input  wire inla_pkg::cmp_sel_type         sel,
   input  wire logic [inla_pkg::END_W-1:0]    stack_end,
   input  wire logic [inla_pkg::TIME_W-1:0]   start_time,
   input  wire logic [inla_pkg::END_W-1:0]    base_end,
   output      logic                          gt
);
   import inla_pkg::*;

   logic [END_W-1:0] op_a;
   logic [END_W-1:0] op_b;

   always_comb begin
      unique case (sel)
         CMP_STACK: begin
            op_a = stack_end;
            op_b = {1'b0, start_time};
         end
         CMP_BASE: begin
            op_a = {1'b0, start_time};
            op_b = base_end;
         end
         default: begin
            op_a = stack_end;
            op_b = {1'b0, start_time};
         end
      endcase
   end

   assign gt = op_a > op_b;

endmodule

`default_nettype wire

@@ rtl/core/interval_nesting_level_assigner.sv @@
// ----------------------------------------------------------------------------
// interval_nesting_level_assigner - nesting levels for start-sorted events
// Assigns each event an overall level and a per-category row from stacks
// of end times, and tracks row counts and the current base event.
//
//   channel  dir  handshake             payload
//   req_     in   req_valid/req_ready   start_time, duration, event_type
//   rsp_     out  rsp_valid/rsp_ready   levels, row count, base index, flag
//   csr_     in   csr_valid/csr_ready   trace_start_time
//
// A request is accepted in idle, walks the overall stack, then the category
// stack (none when out of range), and then finishes. A walk reads the stack
// top and compares it; it goes one level deeper or saturates, or pops levels
// down to the base or until it stops under an open parent, and then writes
// the new end time; each probe is a read and a compare in the
// shared unit on one memory port. Reset is synchronous and needs no clearing
// pass. A stalled response holds in the output register; the next request is
// accepted meanwhile and waits at the end of its walk. Register writes wait
// for idle.
// ----------------------------------------------------------------------------
`default_nettype none

module interval_nesting_level_assigner #(
   parameter int MAX_DEPTH      = 32,
   parameter int NUM_CATEGORIES = 5,
   parameter int LEVEL_BASE     = 1,
   parameter int INDEX_BITS     = 24
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          req_valid,
   output      logic                          req_ready,
   input  wire logic [inla_pkg::TIME_W-1:0]   req_start_time,
   input  wire logic [inla_pkg::TIME_W-1:0]   req_duration,
   input  wire logic [inla_pkg::TYPE_W-1:0]   req_event_type,
   output      logic                          rsp_valid,
   input  wire logic                          rsp_ready,
   output      logic [inla_pkg::LEVEL_W-1:0]  rsp_overall_level,
   output      logic [inla_pkg::LEVEL_W-1:0]  rsp_category_row,
   output      logic [inla_pkg::ROWS_W-1:0]   rsp_category_rows_total,
   output      logic [INDEX_BITS-1:0]         rsp_base_event_index,
   output      logic                          rsp_depth_overflow,
   input  wire logic                          csr_valid,
   output      logic                          csr_ready,
   input  wire logic [inla_pkg::TIME_W-1:0]   csr_trace_start_time
);
   import inla_pkg::*;

   localparam int LW      = (MAX_DEPTH > 1) ? $clog2(MAX_DEPTH) : 1;
   localparam int SW      = $clog2(NUM_CATEGORIES + 1);
   localparam int CW      = (NUM_CATEGORIES > 1) ? $clog2(NUM_CATEGORIES) : 1;
   localparam int ENTRIES = (NUM_CATEGORIES + 1) * (2 ** LW);
   localparam int AW      = $clog2(ENTRIES);

   localparam logic [LW-1:0] LVL_BASE = LW'(LEVEL_BASE);
   localparam logic [LW-1:0] LVL_TOP  = LW'(MAX_DEPTH - 1);
   localparam logic [SW-1:0] STK_ALL  = SW'(NUM_CATEGORIES);

   typedef enum logic [2:0] {
      S_IDLE,
      S_READ_TOP,
      S_TOP,
      S_POP_READ,
      S_POP,
      S_WRITE,
      S_FINISH
   } state_type;

   state_type state_ff;

   logic [TIME_W-1:0]     start_ff;
   logic [END_W-1:0]      end_ff;
   logic [TYPE_W-1:0]     cat_ff;
   logic                  cat_ok_ff;
   logic [SW-1:0]         stk_ff;
   logic [LW-1:0]         lvl_ff;
   logic                  ovf_ff;
   logic [LEVEL_W-1:0]    row_ff;
   logic [ROWS_W-1:0]     rows_ff;

   logic [LW-1:0]         ovr_depth_ff;
   logic [LW-1:0]         cat_depth_ff [NUM_CATEGORIES];
   logic [ROWS_W-1:0]     cat_rows_ff  [NUM_CATEGORIES];
   logic [INDEX_BITS-1:0] item_cnt_ff;
   logic [INDEX_BITS-1:0] base_index_ff;
   logic [END_W-1:0]      base_end_ff;

   logic                  rsp_valid_ff;
   logic [LEVEL_W-1:0]    rsp_level_ff;
   logic [LEVEL_W-1:0]    rsp_row_ff;
   logic [ROWS_W-1:0]     rsp_rows_ff;
   logic [INDEX_BITS-1:0] rsp_base_ff;
   logic                  rsp_ovf_ff;

   logic                  mem_rd_en;
   logic [AW-1:0]         mem_rd_addr;
   logic [END_W-1:0]      mem_rd_data;
   logic                  mem_wr_en;
   logic [AW-1:0]         mem_wr_addr;
   cmp_sel_type           cmp_sel;
   logic                  cmp_gt;
   logic                  req_fire;
   logic                  out_free;
   logic                  base_hit;
   logic [CW-1:0]         cur_cat;
   logic [CW-1:0]         new_cat;
   logic [LW-1:0]         lvl_dec;

   assign req_ready = (state_ff == S_IDLE);
   assign req_fire  = req_valid && req_ready;
   assign csr_ready = (state_ff == S_IDLE);
   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign cur_cat   = CW'(stk_ff);
   assign new_cat   = CW'(cat_ff);
   assign lvl_dec   = lvl_ff - LW'(1);
   assign base_hit  = (ovr_depth_ff == LVL_BASE) && cmp_gt;

   always_comb begin
      mem_rd_en   = 1'b0;
      mem_rd_addr = AW'({stk_ff, lvl_ff});
      if (state_ff == S_READ_TOP) begin
         mem_rd_en = 1'b1;
      end else if (state_ff == S_POP_READ && lvl_ff > LVL_BASE) begin
         mem_rd_en   = 1'b1;
         mem_rd_addr = AW'({stk_ff, lvl_dec});
      end
   end

   assign mem_wr_en   = (state_ff == S_WRITE);
   assign mem_wr_addr = AW'({stk_ff, lvl_ff});
   assign cmp_sel     = (state_ff == S_FINISH) ? CMP_BASE : CMP_STACK;

   inla_stack_mem #(
      .ENTRIES (ENTRIES),
      .AW      (AW)
   ) u_stack_mem (
      .clock   (clock),
      .reset   (reset),
      .rd_en   (mem_rd_en),
      .rd_addr (mem_rd_addr),
      .rd_data (mem_rd_data),
      .wr_en   (mem_wr_en),
      .wr_addr (mem_wr_addr),
      .wr_data (end_ff)
   );

   inla_cmp_unit u_cmp_unit (
      .sel        (cmp_sel),
      .stack_end  (mem_rd_data),
      .start_time (start_ff),
      .base_end   (base_end_ff),
      .gt         (cmp_gt)
   );

   // payload registers
   always_ff @(posedge clock) begin
      if (req_fire) begin
         start_ff  <= req_start_time;
         end_ff    <= {1'b0, req_start_time} + {1'b0, req_duration};
         cat_ff    <= req_event_type;
         cat_ok_ff <= 32'(req_event_type) < NUM_CATEGORIES;
      end
      if (state_ff == S_FINISH && out_free) begin
         rsp_level_ff <= LEVEL_W'(ovr_depth_ff);
         rsp_row_ff   <= row_ff;
         rsp_rows_ff  <= rows_ff;
         rsp_ovf_ff   <= ovf_ff;
         rsp_base_ff  <= base_hit ? item_cnt_ff : base_index_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         stk_ff        <= STK_ALL;
         lvl_ff        <= LVL_BASE;
         ovf_ff        <= 1'b0;
         row_ff        <= LEVEL_W'(LEVEL_BASE);
         rows_ff       <= ROWS_W'(1);
         ovr_depth_ff  <= LVL_BASE;
         for (int c = 0; c < NUM_CATEGORIES; c++) begin
            cat_depth_ff[c] <= LVL_BASE;
            cat_rows_ff[c]  <= ROWS_W'(1);
         end
         item_cnt_ff   <= '0;
         base_index_ff <= '0;
         base_end_ff   <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         if (state_ff == S_FINISH && out_free) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_valid_ff && rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
         if (csr_valid && csr_ready) begin
            base_end_ff <= {1'b0, csr_trace_start_time};
         end
         unique case (state_ff)
            S_IDLE: begin
               if (req_fire) begin
                  stk_ff   <= STK_ALL;
                  lvl_ff   <= ovr_depth_ff;
                  ovf_ff   <= 1'b0;
                  state_ff <= S_READ_TOP;
               end
            end
            S_READ_TOP: begin
               state_ff <= S_TOP;
            end
            S_TOP: begin
               if (cmp_gt) begin
                  // go one level deeper, or saturate
                  if (lvl_ff == LVL_TOP) begin
                     ovf_ff <= 1'b1;
                  end else begin
                     lvl_ff <= lvl_ff + LW'(1);
                  end
                  state_ff <= S_WRITE;
               end else begin
                  state_ff <= S_POP_READ;
               end
            end
            S_POP_READ: begin
               state_ff <= (lvl_ff > LVL_BASE) ? S_POP : S_WRITE;
            end
            S_POP: begin
               // drop the level while its parent has already ended
               if (!cmp_gt) begin
                  lvl_ff   <= lvl_dec;
                  state_ff <= S_POP_READ;
               end else begin
                  state_ff <= S_WRITE;
               end
            end
            S_WRITE: begin
               if (stk_ff == STK_ALL) begin
                  ovr_depth_ff <= lvl_ff;
                  if (cat_ok_ff) begin
                     stk_ff   <= SW'(cat_ff);
                     lvl_ff   <= cat_depth_ff[new_cat];
                     state_ff <= S_READ_TOP;
                  end else begin
                     row_ff   <= LEVEL_W'(LEVEL_BASE);
                     rows_ff  <= ROWS_W'(1);
                     state_ff <= S_FINISH;
                  end
               end else begin
                  cat_depth_ff[cur_cat] <= lvl_ff;
                  row_ff <= LEVEL_W'(lvl_ff);
                  if (cat_rows_ff[cur_cat] <= ROWS_W'(lvl_ff)) begin
                     cat_rows_ff[cur_cat] <= ROWS_W'(lvl_ff) + ROWS_W'(1);
                     rows_ff              <= ROWS_W'(lvl_ff) + ROWS_W'(1);
                  end else begin
                     rows_ff <= cat_rows_ff[cur_cat];
                  end
                  state_ff <= S_FINISH;
               end
            end
            S_FINISH: begin
               // hold until the output register is free
               if (out_free) begin
                  if (base_hit) begin
                     base_index_ff <= item_cnt_ff;
                     base_end_ff   <= end_ff;
                  end
                  item_cnt_ff  <= item_cnt_ff + INDEX_BITS'(1);
                  state_ff     <= S_IDLE;
               end
            end
            default: begin
               state_ff <= S_IDLE;
            end
         endcase
      end
   end

   assign rsp_valid               = rsp_valid_ff;
   assign rsp_overall_level       = rsp_level_ff;
   assign rsp_category_row        = rsp_row_ff;
   assign rsp_category_rows_total = rsp_rows_ff;
   assign rsp_base_event_index    = rsp_base_ff;
   assign rsp_depth_overflow      = rsp_ovf_ff;

endmodule

`default_nettype wire

@@ tb/sv/inla_tb_pkg.sv @@
// ----------------------------------------------------------------------------
// inla_tb_pkg - level predictor and response scoreboard
// Tracks the end-time stacks of the nesting level assigner, predicts the
// response of every accepted request and checks the responses in order.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

package inla_tb_pkg;

   import inla_pkg::*;

   localparam int MAX_DEPTH      = 32;
   localparam int NUM_CATEGORIES = 5;
   localparam int LEVEL_BASE     = 1;
   localparam int INDEX_BITS     = 24;
   localparam int ALL_STACK      = NUM_CATEGORIES;
   localparam int NUM_STACKS     = NUM_CATEGORIES + 1;
   localparam int REPORT_LIMIT   = 10;

   typedef struct packed {
      logic [LEVEL_W-1:0]    overall_level;
      logic [LEVEL_W-1:0]    category_row;
      logic [ROWS_W-1:0]     rows_total;
      logic [INDEX_BITS-1:0] base_index;
      logic                  overflow;
   } level_result_type;

   class level_scoreboard;
      logic [END_W-1:0]      ends [NUM_STACKS][MAX_DEPTH];
      int unsigned           depth [NUM_STACKS];
      int unsigned           row_count [NUM_CATEGORIES];
      logic [INDEX_BITS-1:0] item_count;
      logic [INDEX_BITS-1:0] base_index;
      logic [END_W-1:0]      base_end;
      bit                    sat_hit;
      level_result_type      expected_q [$];
      int unsigned           errors;
      int unsigned           checked;
      int unsigned           deepest;
      int unsigned           saturated;
      int unsigned           stray_category;

      function new();
         foreach (ends[s, d]) ends[s][d] = '0;
         foreach (depth[s]) depth[s] = LEVEL_BASE;
         foreach (row_count[c]) row_count[c] = 1;
         item_count = '0;
         base_index = '0;
         base_end = '0;
         sat_hit = 1'b0;
         errors = 0;
         checked = 0;
         deepest = 0;
         saturated = 0;
         stray_category = 0;
      endfunction

      function void set_trace_start(logic [TIME_W-1:0] value);
         base_end = {1'b0, value};
      endfunction

      // Go one level deeper, or pop levels whose parent has ended.
      function int unsigned nest(int unsigned s, logic [END_W-1:0] st,
                                 logic [END_W-1:0] fin);
         int unsigned lv;
         lv = depth[s];
         if (lv >= MAX_DEPTH) lv = MAX_DEPTH - 1;
         if (ends[s][lv] > st) begin
            if (lv + 1 < MAX_DEPTH) lv++;
            else sat_hit = 1'b1;
         end else begin
            while (lv > LEVEL_BASE && ends[s][lv - 1] <= st) lv--;
         end
         ends[s][lv] = fin;
         depth[s] = lv;
         return lv;
      endfunction

      function void note_request(logic [TIME_W-1:0] st, logic [TIME_W-1:0] dur,
                                 logic [TYPE_W-1:0] typ);
         logic [END_W-1:0] st_w;
         logic [END_W-1:0] fin;
         int unsigned      lvl;
         int unsigned      row;
         int unsigned      rows;
         int unsigned      c;
         level_result_type want;
         st_w = {1'b0, st};
         fin = {1'b0, st} + {1'b0, dur};
         sat_hit = 1'b0;
         row = LEVEL_BASE;
         rows = 1;
         lvl = nest(ALL_STACK, st_w, fin);
         c = int'(typ);
         if (c < NUM_CATEGORIES) begin
            row = nest(c, st_w, fin);
            if (row_count[c] <= row) row_count[c] = row + 1;
            rows = row_count[c];
         end else begin
            stray_category++;
         end
         if (lvl == LEVEL_BASE && base_end < st_w) begin
            base_index = item_count;
            base_end = fin;
         end
         want.overall_level = LEVEL_W'(lvl);
         want.category_row = LEVEL_W'(row);
         want.rows_total = ROWS_W'(rows);
         want.base_index = base_index;
         want.overflow = sat_hit;
         expected_q.push_back(want);
         if (lvl > deepest) deepest = lvl;
         if (sat_hit) saturated++;
         item_count = item_count + 1'b1;
      endfunction

      function void check_response(level_result_type got);
         level_result_type want;
         if (expected_q.size() == 0) begin
            errors++;
            if (errors <= REPORT_LIMIT)
               $display("%0t: response with no request pending: level %0d row %0d",
                        $time, got.overall_level, got.category_row);
            return;
         end
         want = expected_q.pop_front();
         checked++;
         if (got.overall_level !== want.overall_level ||
             got.category_row !== want.category_row ||
             got.rows_total !== want.rows_total ||
             got.base_index !== want.base_index ||
             got.overflow !== want.overflow) begin
            errors++;
            if (errors <= REPORT_LIMIT)
               $display({"%0t: response %0d mismatch (exp/got): level %0d/%0d ",
                         "row %0d/%0d rows %0d/%0d base %0d/%0d ovf %0b/%0b"},
                        $time, checked, want.overall_level, got.overall_level,
                        want.category_row, got.category_row,
                        want.rows_total, got.rows_total,
                        want.base_index, got.base_index,
                        want.overflow, got.overflow);
         end
      endfunction

      function int unsigned pending();
         return expected_q.size();
      endfunction
   endclass

endpackage

@@ tb/sv/tb_interval_nesting_level_assigner.sv @@
// ----------------------------------------------------------------------------
// tb_interval_nesting_level_assigner - testbench of the nesting level assigner
// Drives timed events through the request channel, writes the trace start
// register between phases and checks every response against a predictor of
// the end-time stacks. Directed events come first, then random phases of
// deep towers, well-formed sorted streams and unsorted noise, with random
// stalls on both channels.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb_interval_nesting_level_assigner;

   import inla_pkg::*;
   import inla_tb_pkg::*;

   localparam int unsigned         RANDOM_ITEMS = 1250;
   localparam int unsigned         CYCLE_LIMIT  = 1000000;
   localparam int unsigned         END_SLACK    = 100;
   localparam logic [TIME_W-1:0]   TIME_MAX     = '1;

   typedef enum {
      SEQ_TOWER,
      SEQ_MIXED,
      SEQ_NOISE
   } seq_kind_type;

   logic                   clock = 1'b0;
   logic                   reset = 1'b1;
   logic                   req_valid = 1'b0;
   logic                   req_ready;
   logic [TIME_W-1:0]      req_start_time = '0;
   logic [TIME_W-1:0]      req_duration = '0;
   logic [TYPE_W-1:0]      req_event_type = '0;
   logic                   rsp_valid;
   logic                   rsp_ready = 1'b0;
   logic [LEVEL_W-1:0]     rsp_overall_level;
   logic [LEVEL_W-1:0]     rsp_category_row;
   logic [ROWS_W-1:0]      rsp_category_rows_total;
   logic [INDEX_BITS-1:0]  rsp_base_event_index;
   logic                   rsp_depth_overflow;
   logic                   csr_valid = 1'b0;
   logic                   csr_ready;
   logic [TIME_W-1:0]      csr_trace_start_time = '0;

   level_scoreboard        levels = new();
   bit                     calm = 1'b0;
   bit                     quiet_tail = 1'b0;
   int unsigned            sent = 0;
   int unsigned            phases = 0;
   int unsigned            csr_writes = 0;
   int unsigned            cycle_count = 0;

   interval_nesting_level_assigner #(
      .MAX_DEPTH      (MAX_DEPTH),
      .NUM_CATEGORIES (NUM_CATEGORIES),
      .LEVEL_BASE     (LEVEL_BASE),
      .INDEX_BITS     (INDEX_BITS)
   ) dut (
      .clock                   (clock),
      .reset                   (reset),
      .req_valid               (req_valid),
      .req_ready               (req_ready),
      .req_start_time          (req_start_time),
      .req_duration            (req_duration),
      .req_event_type          (req_event_type),
      .rsp_valid               (rsp_valid),
      .rsp_ready               (rsp_ready),
      .rsp_overall_level       (rsp_overall_level),
      .rsp_category_row        (rsp_category_row),
      .rsp_category_rows_total (rsp_category_rows_total),
      .rsp_base_event_index    (rsp_base_event_index),
      .rsp_depth_overflow      (rsp_depth_overflow),
      .csr_valid               (csr_valid),
      .csr_ready               (csr_ready),
      .csr_trace_start_time    (csr_trace_start_time)
   );

   initial forever #2 clock = ~clock;

   initial begin
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("tb_interval_nesting_level_assigner: FAIL");
      $finish;
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready)
         levels.check_response({rsp_overall_level, rsp_category_row,
                                rsp_category_rows_total, rsp_base_event_index,
                                rsp_depth_overflow});
   end

   initial begin
      @(posedge clock);
      forever begin
         if (!quiet_tail && !calm && $urandom_range(0, 3) == 0) begin
            rsp_ready <= 1'b0;
            repeat ($urandom_range(1, 18)) @(posedge clock);
         end
         rsp_ready <= 1'b1;
         repeat ($urandom_range(1, 24)) @(posedge clock);
      end
   end

   function automatic logic [TIME_W-1:0] rand_time();
      logic [63:0] r;
      r = {$urandom, $urandom};
      return r[TIME_W-1:0];
   endfunction

   function automatic logic [TIME_W-1:0] advance(input logic [TIME_W-1:0] t,
                                                 input int unsigned step);
      logic [TIME_W:0] sum;
      sum = {1'b0, t} + (TIME_W + 1)'(step);
      return sum[TIME_W] ? TIME_MAX : sum[TIME_W-1:0];
   endfunction

   function automatic logic [TIME_W-1:0] pick_duration();
      int unsigned r;
      r = $urandom_range(0, 99);
      if (r < 72) return TIME_W'($urandom_range(0, 40));
      if (r < 97) return TIME_W'($urandom_range(0, 400));
      if (r < 99) return rand_time();
      return TIME_MAX;
   endfunction

   function automatic logic [TYPE_W-1:0] pick_type();
      if ($urandom_range(0, 9) == 0)
         return TYPE_W'($urandom_range(NUM_CATEGORIES, (1 << TYPE_W) - 1));
      return TYPE_W'($urandom_range(0, NUM_CATEGORIES - 1));
   endfunction

   task automatic send_request(input logic [TIME_W-1:0] st,
                               input logic [TIME_W-1:0] dur,
                               input logic [TYPE_W-1:0] typ);
      req_valid <= 1'b1;
      req_start_time <= st;
      req_duration <= dur;
      req_event_type <= typ;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      levels.note_request(st, dur, typ);
      sent++;
      if (!quiet_tail && !calm && $urandom_range(0, 5) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 18)) @(posedge clock);
      end
   endtask

   // Hold off requests until every response is back.
   task automatic drain();
      req_valid <= 1'b0;
      do @(posedge clock); while (levels.pending() != 0);
   endtask

   task automatic write_trace_start(input logic [TIME_W-1:0] value);
      csr_valid <= 1'b1;
      csr_trace_start_time <= value;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      levels.set_trace_start(value);
      csr_writes++;
      csr_valid <= 1'b0;
   endtask

   task automatic run_directed();
      write_trace_start('0);
      send_request(62'd5, 62'd100, 3'd0);
      send_request(62'd10, 62'd20, 3'd0);
      send_request(62'd12, 62'd3, 3'd1);
      send_request(62'd15, 62'd0, 3'd5);
      send_request(62'd40, 62'd5, 3'd7);
      send_request(62'd40, 62'd60, 3'd2);
      send_request(62'd200, 62'd1, 3'd2);
      send_request(62'd200, 62'd0, 3'd3);
      send_request(62'd201, TIME_MAX, 3'd4);
      send_request(62'd202, 62'd10, 3'd4);
      // out of order start
      send_request(62'd50, 62'd10, 3'd0);
      send_request(62'd0, 62'd0, 3'd6);
      send_request(TIME_MAX, 62'd0, 3'd1);
      send_request(TIME_MAX, TIME_MAX, 3'd4);
      send_request(TIME_MAX, TIME_MAX, 3'd0);
      drain();
      write_trace_start(TIME_MAX);
      send_request(62'd0, 62'd7, 3'd3);
      send_request(TIME_MAX, 62'd1, 3'd3);
      drain();
      write_trace_start(62'h2AAA_AAAA_AAAA_AAAA);
      send_request(62'h1555_5555_5555_5555, 62'h2AAA_AAAA_AAAA_AAAA, 3'd2);
      send_request(62'h2AAA_AAAA_AAAA_AAAB, 62'd3, 3'd2);
   endtask

   task automatic run_random();
      logic [TIME_W-1:0] stamp;
      seq_kind_type      kind;
      int unsigned       first;
      int unsigned       n;
      int unsigned       r;
      int unsigned       cat;
      bit                one_cat;
      stamp = '0;
      first = sent;
      while (sent - first < RANDOM_ITEMS) begin
         phases++;
         calm = ($urandom_range(0, 3) == 0);
         quiet_tail = (sent - first + 150 >= RANDOM_ITEMS);
         case ($urandom_range(0, 3))
            0: stamp = TIME_W'($urandom_range(0, 1000));
            1: stamp = rand_time();
            2: stamp = TIME_MAX - TIME_W'($urandom_range(0, 5000));
            default: ;
         endcase
         if (phases == 1 || $urandom_range(0, 2) == 0) begin
            drain();
            case ($urandom_range(0, 4))
               0: write_trace_start('0);
               1: write_trace_start(TIME_MAX);
               2: write_trace_start(stamp);
               default: write_trace_start(rand_time());
            endcase
         end
         r = $urandom_range(0, 19);
         kind = (r < 4) ? SEQ_TOWER : ((r < 17) ? SEQ_MIXED : SEQ_NOISE);
         if (phases == 1) kind = SEQ_TOWER;
         case (kind)
            SEQ_TOWER: begin
               // each event ends before its parent: climb toward saturation
               n = $urandom_range(30, 40);
               cat = $urandom_range(0, NUM_CATEGORIES - 1);
               one_cat = ($urandom_range(0, 1) == 0);
               for (int unsigned i = 0; i < n; i++)
                  send_request(advance(stamp, i), TIME_W'(1000 + (n - i) * 4),
                               one_cat ? TYPE_W'(cat) : pick_type());
               stamp = advance(stamp, n);
            end
            SEQ_MIXED: begin
               n = $urandom_range(20, 80);
               for (int unsigned i = 0; i < n; i++) begin
                  stamp = advance(stamp, ($urandom_range(0, 9) < 3) ?
                                         0 : $urandom_range(1, 12));
                  send_request(stamp, pick_duration(), pick_type());
               end
            end
            default: begin
               n = $urandom_range(8, 25);
               for (int unsigned i = 0; i < n; i++)
                  send_request(($urandom_range(0, 1) == 0) ?
                                  rand_time() : TIME_W'($urandom_range(0, 2000)),
                               ($urandom_range(0, 1) == 0) ?
                                  rand_time() : TIME_W'($urandom_range(0, 100)),
                               TYPE_W'($urandom_range(0, (1 << TYPE_W) - 1)));
            end
         endcase
      end
   endtask

   initial begin
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      run_directed();
      run_random();
      req_valid <= 1'b0;
      while (levels.pending() != 0) @(posedge clock);
      repeat (END_SLACK) @(posedge clock);
      $display("%0d requests over %0d random phases, %0d trace start writes, %0d checked",
               sent, phases, csr_writes, levels.checked);
      $display("deepest level %0d, %0d saturated, %0d out-of-range categories, %0d errors",
               levels.deepest, levels.saturated, levels.stray_category, levels.errors);
      if (levels.errors == 0 && levels.pending() == 0) begin
         $display("tb_interval_nesting_level_assigner: PASS");
      end else begin
         $display("tb_interval_nesting_level_assigner: FAIL");
      end
      $finish;
   end

endmodule
